// ===== rtl/tsqm_pkg.sv =====
// tsqm_pkg: shared types, constants and codes for the touch sample qualifier
// used by every module of touch_sample_qualify_map_top; depends on nothing

package tsqm_pkg;

  // field widths
  localparam int unsigned COORD_W = 12;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DEB_W   = 16;
  localparam int unsigned FLAG_W  = 4;
  localparam int unsigned PROD_W  = 2 * COORD_W;

  // screen size, as mapped output range
  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 240;
  localparam logic [COORD_W-1:0] X_MAX = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(SCREEN_HEIGHT - 1);

  // divider steps, one quotient bit each
  localparam int unsigned DIV_STEPS = COORD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  // stream widths
  localparam int unsigned S_DATA_W = 72;
  localparam int unsigned M_DATA_W = 64;
  localparam int unsigned M_USER_W = 3;

  // configuration port
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_X_LOW    = 3'd0,
    REG_X_HIGH   = 3'd1,
    REG_Y_LOW    = 3'd2,
    REG_Y_HIGH   = 3'd3,
    REG_P_LOW    = 3'd4,
    REG_P_HIGH   = 3'd5,
    REG_ORIENT   = 3'd6,
    REG_DEBOUNCE = 3'd7
  } reg_idx_e;

  // orientation flag bits
  localparam int unsigned OF_SWAP  = 0;
  localparam int unsigned OF_INV_X = 1;
  localparam int unsigned OF_INV_Y = 2;
  localparam int unsigned OF_IRQ   = 3;

  // register reset values
  localparam logic [COORD_W-1:0] RST_X_LOW    = 12'd350;
  localparam logic [COORD_W-1:0] RST_X_HIGH   = 12'd3800;
  localparam logic [COORD_W-1:0] RST_Y_LOW    = 12'd300;
  localparam logic [COORD_W-1:0] RST_Y_HIGH   = 12'd3800;
  localparam logic [COORD_W-1:0] RST_P_LOW    = 12'd200;
  localparam logic [COORD_W-1:0] RST_P_HIGH   = 12'd4095;
  localparam logic [FLAG_W-1:0]  RST_ORIENT   = 4'd2;
  localparam logic [DEB_W-1:0]   RST_DEBOUNCE = 16'd220;

  typedef enum logic [1:0] {
    REJ_NONE     = 2'd0,
    REJ_PEN_UP   = 2'd1,
    REJ_PRESSURE = 2'd2,
    REJ_DEBOUNCE = 2'd3
  } rej_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0] x_low;
    logic [COORD_W-1:0] x_high;
    logic [COORD_W-1:0] y_low;
    logic [COORD_W-1:0] y_high;
    logic [COORD_W-1:0] p_low;
    logic [COORD_W-1:0] p_high;
    logic [FLAG_W-1:0]  orient;
    logic [DEB_W-1:0]   debounce;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic take;       // sample transaction accepted
    logic take_last;  // accepted sample closes the burst
    logic check;      // register qualification result
    logic setup;      // clamp and span of current axis
    logic mul;        // scale product
    logic div_step;   // one quotient bit
    logic fin;        // store mapped coordinate
    logic axis_y;     // 0 x axis, 1 y axis
    logic load_out;   // fill output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic accept;     // qualification passes
    logic out_free;   // output register can take a result
  } status_t;

endpackage

// ===== rtl/touch_sample_qualify_map_top.sv =====
// Touch sample qualifier and calibration mapper, top level.
// A burst's last sample is qualified; when accepted it is mapped x then y (per axis:
// setup, multiply, 12 divider steps, store) by the shared restoring divider.
// Throughput: one sample per cycle inside a burst; after a closing sample the input
// is not ready again until its result is loaded into the output register.
// Reset (rst_ni, async, low): registers to defaults, best sample and last time to 0.

module touch_sample_qualify_map_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // raw_x[11:0], raw_y[23:12], raw_z[35:24], now_ms[67:36], zero[71:68]
  input  logic [tsqm_pkg::S_DATA_W-1:0]      s_axis_tdata,
  // pen_down
  input  logic                               s_axis_tuser,
  // burst_last
  input  logic                               s_axis_tlast,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // screen_x[11:0], screen_y[23:12], best_x[35:24], best_y[47:36],
  // best_z[59:48], zero[63:60]
  output logic [tsqm_pkg::M_DATA_W-1:0]      m_axis_tdata,
  // touched[0], reject_code[2:1]
  output logic [tsqm_pkg::M_USER_W-1:0]      m_axis_tuser,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tsqm_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  tsqm_pkg::cfg_t    cfg;
  tsqm_pkg::cmd_t    cmd;
  tsqm_pkg::status_t status;
  logic              touched;
  tsqm_pkg::rej_e    reject_code;
  logic [tsqm_pkg::COORD_W-1:0] screen_x, screen_y, best_x, best_y, best_z;

  tsqm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsqm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  tsqm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .status_o      (status),
    .raw_x_i       (s_axis_tdata[11:0]),
    .raw_y_i       (s_axis_tdata[23:12]),
    .raw_z_i       (s_axis_tdata[35:24]),
    .pen_down_i    (s_axis_tuser),
    .now_ms_i      (s_axis_tdata[67:36]),
    .m_tready_i    (m_axis_tready),
    .m_tvalid_o    (m_axis_tvalid),
    .touched_o     (touched),
    .reject_code_o (reject_code),
    .screen_x_o    (screen_x),
    .screen_y_o    (screen_y),
    .best_x_o      (best_x),
    .best_y_o      (best_y),
    .best_z_o      (best_z)
  );

  // pack result transaction
  assign m_axis_tdata = {4'b0, best_z, best_y, best_x, screen_y, screen_x};
  assign m_axis_tuser = {reject_code, touched};

endmodule

// ===== rtl/tsqm_regs.sv =====
// tsqm_regs: APB-style configuration registers of the touch qualifier
// depends on tsqm_pkg

module tsqm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsqm_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output tsqm_pkg::cfg_t                cfg_o
);

  tsqm_pkg::cfg_t   cfg_q;
  tsqm_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = tsqm_pkg::reg_idx_e'(paddr[tsqm_pkg::ADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_low    <= tsqm_pkg::RST_X_LOW;
      cfg_q.x_high   <= tsqm_pkg::RST_X_HIGH;
      cfg_q.y_low    <= tsqm_pkg::RST_Y_LOW;
      cfg_q.y_high   <= tsqm_pkg::RST_Y_HIGH;
      cfg_q.p_low    <= tsqm_pkg::RST_P_LOW;
      cfg_q.p_high   <= tsqm_pkg::RST_P_HIGH;
      cfg_q.orient   <= tsqm_pkg::RST_ORIENT;
      cfg_q.debounce <= tsqm_pkg::RST_DEBOUNCE;
    end else if (wr_en) begin
      unique case (idx)
        tsqm_pkg::REG_X_LOW:    cfg_q.x_low    <= pwdata[tsqm_pkg::COORD_W-1:0];
        tsqm_pkg::REG_X_HIGH:   cfg_q.x_high   <= pwdata[tsqm_pkg::COORD_W-1:0];
        tsqm_pkg::REG_Y_LOW:    cfg_q.y_low    <= pwdata[tsqm_pkg::COORD_W-1:0];
        tsqm_pkg::REG_Y_HIGH:   cfg_q.y_high   <= pwdata[tsqm_pkg::COORD_W-1:0];
        tsqm_pkg::REG_P_LOW:    cfg_q.p_low    <= pwdata[tsqm_pkg::COORD_W-1:0];
        tsqm_pkg::REG_P_HIGH:   cfg_q.p_high   <= pwdata[tsqm_pkg::COORD_W-1:0];
        tsqm_pkg::REG_ORIENT:   cfg_q.orient   <= pwdata[tsqm_pkg::FLAG_W-1:0];
        tsqm_pkg::REG_DEBOUNCE: cfg_q.debounce <= pwdata[tsqm_pkg::DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      tsqm_pkg::REG_X_LOW:    prdata = 32'(cfg_q.x_low);
      tsqm_pkg::REG_X_HIGH:   prdata = 32'(cfg_q.x_high);
      tsqm_pkg::REG_Y_LOW:    prdata = 32'(cfg_q.y_low);
      tsqm_pkg::REG_Y_HIGH:   prdata = 32'(cfg_q.y_high);
      tsqm_pkg::REG_P_LOW:    prdata = 32'(cfg_q.p_low);
      tsqm_pkg::REG_P_HIGH:   prdata = 32'(cfg_q.p_high);
      tsqm_pkg::REG_ORIENT:   prdata = 32'(cfg_q.orient);
      tsqm_pkg::REG_DEBOUNCE: prdata = 32'(cfg_q.debounce);
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== rtl/tsqm_ctrl.sv =====
// tsqm_ctrl: sequencing state machine of the touch qualifier
// depends on tsqm_pkg; drives tsqm_dp through cmd_t, reads status_t

module tsqm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tlast,
  output logic                s_axis_tready,
  input  tsqm_pkg::status_t   status_i,
  output tsqm_pkg::cmd_t      cmd_o
);

  tsqm_pkg::state_e           state_q, state_d;
  logic                       axis_q, axis_d;
  logic [tsqm_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       take;

  assign s_axis_tready = (state_q == tsqm_pkg::ST_IDLE);
  assign take          = s_axis_tvalid & s_axis_tready;

  // state, axis and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsqm_pkg::ST_IDLE;
      axis_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d         = state_q;
    axis_d          = axis_q;
    cnt_d           = cnt_q;
    cmd_o           = '0;
    cmd_o.axis_y    = axis_q;
    unique case (state_q)
      tsqm_pkg::ST_IDLE: begin
        cmd_o.take      = take;
        cmd_o.take_last = take & s_axis_tlast;
        if (take && s_axis_tlast) begin
          state_d = tsqm_pkg::ST_CHECK;
        end
      end
      tsqm_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        axis_d      = 1'b0;
        state_d     = status_i.accept ? tsqm_pkg::ST_SETUP : tsqm_pkg::ST_DONE;
      end
      tsqm_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = tsqm_pkg::ST_MUL;
      end
      tsqm_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = tsqm_pkg::ST_DIV;
      end
      tsqm_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == tsqm_pkg::CNT_W'(tsqm_pkg::DIV_STEPS - 1)) begin
          state_d = tsqm_pkg::ST_FIN;
        end
      end
      tsqm_pkg::ST_FIN: begin
        cmd_o.fin = 1'b1;
        if (axis_q) begin
          state_d = tsqm_pkg::ST_DONE;
        end else begin
          axis_d  = 1'b1;
          state_d = tsqm_pkg::ST_SETUP;
        end
      end
      tsqm_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = tsqm_pkg::ST_IDLE;
        end
      end
      default: state_d = tsqm_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/tsqm_dp.sv =====
// tsqm_dp: datapath of the touch qualifier: best sample, checks,
// clamp, scale multiply, restoring divider and output register; depends on tsqm_pkg

module tsqm_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tsqm_pkg::cfg_t                      cfg_i,
  input  tsqm_pkg::cmd_t                      cmd_i,
  output tsqm_pkg::status_t                   status_o,
  input  logic [tsqm_pkg::COORD_W-1:0]        raw_x_i,
  input  logic [tsqm_pkg::COORD_W-1:0]        raw_y_i,
  input  logic [tsqm_pkg::COORD_W-1:0]        raw_z_i,
  input  logic                                pen_down_i,
  input  logic [tsqm_pkg::TIME_W-1:0]         now_ms_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic                                touched_o,
  output tsqm_pkg::rej_e                      reject_code_o,
  output logic [tsqm_pkg::COORD_W-1:0]        screen_x_o,
  output logic [tsqm_pkg::COORD_W-1:0]        screen_y_o,
  output logic [tsqm_pkg::COORD_W-1:0]        best_x_o,
  output logic [tsqm_pkg::COORD_W-1:0]        best_y_o,
  output logic [tsqm_pkg::COORD_W-1:0]        best_z_o
);

  localparam int unsigned CW = tsqm_pkg::COORD_W;

  // running best of the burst
  logic [CW-1:0] run_x_q, run_y_q, run_z_q;
  logic          wins;

  // burst snapshot
  logic [CW-1:0]                  bx_q, by_q, bz_q;
  logic                           pen_q;
  logic [tsqm_pkg::TIME_W-1:0]    now_q;
  logic [tsqm_pkg::TIME_W-1:0]    last_time_q;
  logic [tsqm_pkg::TIME_W-1:0]    elapsed;
  tsqm_pkg::rej_e                 code_d, code_q;

  // axis mapping
  logic [CW-1:0]         v_sel, lo_sel, hi_sel, size_m1, clamped;
  logic                  inv_sel;
  logic [CW-1:0]         diff_q, span_q;
  logic                  ok_q, inv_q;
  logic [tsqm_pkg::PROD_W-1:0] prod;
  logic [CW-1:0]         rem_q, quo_q;
  logic [CW:0]           rem_ext, rem_sub;
  logic                  ge;
  logic [CW-1:0]         mapped;
  logic [CW-1:0]         sx_q, sy_q;

  // output register
  logic                  out_valid_q;
  logic                  touched_q;
  tsqm_pkg::rej_e        rej_q;
  logic [CW-1:0]         osx_q, osy_q, obx_q, oby_q, obz_q;

  assign wins = raw_z_i > run_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_x_q <= '0;
      run_y_q <= '0;
      run_z_q <= '0;
    end else if (cmd_i.take_last) begin
      run_x_q <= '0;
      run_y_q <= '0;
      run_z_q <= '0;
    end else if (cmd_i.take && wins) begin
      run_x_q <= raw_x_i;
      run_y_q <= raw_y_i;
      run_z_q <= raw_z_i;
    end
  end

  // snapshot of the closing burst
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_last) begin
      bx_q  <= wins ? raw_x_i : run_x_q;
      by_q  <= wins ? raw_y_i : run_y_q;
      bz_q  <= wins ? raw_z_i : run_z_q;
      pen_q <= pen_down_i;
      now_q <= now_ms_i;
    end
  end

  // qualification: pen, pressure window, debounce
  assign elapsed = now_q - last_time_q;

  always_comb begin
    if (cfg_i.orient[tsqm_pkg::OF_IRQ] && !pen_q) begin
      code_d = tsqm_pkg::REJ_PEN_UP;
    end else if (bz_q < cfg_i.p_low || bz_q > cfg_i.p_high) begin
      code_d = tsqm_pkg::REJ_PRESSURE;
    end else if (elapsed < tsqm_pkg::TIME_W'(cfg_i.debounce)) begin
      code_d = tsqm_pkg::REJ_DEBOUNCE;
    end else begin
      code_d = tsqm_pkg::REJ_NONE;
    end
  end

  assign status_o.accept   = (code_d == tsqm_pkg::REJ_NONE);
  assign status_o.out_free = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
    end else if (cmd_i.check && code_d == tsqm_pkg::REJ_NONE) begin
      last_time_q <= now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      code_q <= code_d;
    end
  end

  // axis operand selection with optional swap
  always_comb begin
    if (cmd_i.axis_y) begin
      v_sel   = cfg_i.orient[tsqm_pkg::OF_SWAP] ? bx_q : by_q;
      lo_sel  = cfg_i.y_low;
      hi_sel  = cfg_i.y_high;
      size_m1 = tsqm_pkg::Y_MAX;
      inv_sel = cfg_i.orient[tsqm_pkg::OF_INV_Y];
    end else begin
      v_sel   = cfg_i.orient[tsqm_pkg::OF_SWAP] ? by_q : bx_q;
      lo_sel  = cfg_i.x_low;
      hi_sel  = cfg_i.x_high;
      size_m1 = tsqm_pkg::X_MAX;
      inv_sel = cfg_i.orient[tsqm_pkg::OF_INV_X];
    end
  end

  // clamp to calibration limits
  always_comb begin
    if (v_sel < lo_sel) begin
      clamped = lo_sel;
    end else if (v_sel > hi_sel) begin
      clamped = hi_sel;
    end else begin
      clamped = v_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      diff_q <= clamped - lo_sel;
      span_q <= hi_sel - lo_sel;
      ok_q   <= hi_sel > lo_sel;
      inv_q  <= inv_sel;
    end
  end

  // scale product, then restoring division; quotient fits in CW bits
  // because the clamped offset never exceeds a nonempty span
  assign prod    = diff_q * size_m1;
  assign rem_ext = {rem_q, quo_q[CW-1]};
  assign ge      = rem_ext >= {1'b0, span_q};
  assign rem_sub = rem_ext - {1'b0, span_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rem_q <= prod[tsqm_pkg::PROD_W-1:CW];
      quo_q <= prod[CW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sub[CW-1:0] : rem_ext[CW-1:0];
      quo_q <= {quo_q[CW-2:0], ge};
    end
  end

  // optional inversion, empty or inverted span gives zero
  always_comb begin
    if (!ok_q) begin
      mapped = '0;
    end else if (inv_q) begin
      mapped = size_m1 - quo_q;
    end else begin
      mapped = quo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      if (cmd_i.axis_y) begin
        sy_q <= mapped;
      end else begin
        sx_q <= mapped;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      touched_q <= (code_q == tsqm_pkg::REJ_NONE);
      rej_q     <= code_q;
      osx_q     <= (code_q == tsqm_pkg::REJ_NONE) ? sx_q : '0;
      osy_q     <= (code_q == tsqm_pkg::REJ_NONE) ? sy_q : '0;
      obx_q     <= bx_q;
      oby_q     <= by_q;
      obz_q     <= bz_q;
    end
  end

  assign m_tvalid_o    = out_valid_q;
  assign touched_o     = touched_q;
  assign reject_code_o = rej_q;
  assign screen_x_o    = osx_q;
  assign screen_y_o    = osy_q;
  assign best_x_o      = obx_q;
  assign best_y_o      = oby_q;
  assign best_z_o      = obz_q;

endmodule

// ===== rtl/tsqm_checker.sv =====
// tsqm_checker: port-level checks on the result stream of the touch qualifier
// depends on tsqm_pkg; bound to touch_sample_qualify_map_top

module tsqm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tsqm_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input logic [tsqm_pkg::M_USER_W-1:0]  m_axis_tuser
);

  // touched goes with an accepted code and nothing else
  a_touched_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] ==
      (m_axis_tuser[2:1] == tsqm_pkg::REJ_NONE)))
    else $error("touched flag disagrees with reject code");

  // rejected touch reports zero screen coordinates
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[23:0] == 24'd0))
    else $error("rejected touch with nonzero screen coordinates");

  // mapped coordinates stay on screen
  a_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[11:0] <= tsqm_pkg::X_MAX && m_axis_tdata[23:12] <= tsqm_pkg::Y_MAX))
    else $error("screen coordinate beyond screen size");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result transaction changed while stalled");

endmodule

bind touch_sample_qualify_map_top tsqm_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_touch_sample_qualify_map_top.sv =====
// testbench for touch_sample_qualify_map_top: streams bursts of touch samples,
// predicts each qualified touch and its screen mapping, checks every result
// depends on tsqm_pkg and the top level only
`timescale 1ns / 100ps

module tb_touch_sample_qualify_map_top;
  import tsqm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned SETTLE_CYC   = 40;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 155;

  typedef struct {
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
    logic [COORD_W-1:0] raw_z;
    logic               pen_down;
    logic               burst_last;
    logic [TIME_W-1:0]  now_ms;
  } sample_t;

  typedef struct {
    logic               touched;
    rej_e               code;
    logic [COORD_W-1:0] scr_x;
    logic [COORD_W-1:0] scr_y;
    logic [COORD_W-1:0] best_x;
    logic [COORD_W-1:0] best_y;
    logic [COORD_W-1:0] best_z;
  } touch_res_t;

  // one line of the directed table: a register write or a sample
  typedef struct {
    bit          is_cfg;
    reg_idx_e    idx;
    logic [31:0] val;
    sample_t     smp;
    bit          lit;
    touch_res_t  res;
  } step_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [M_USER_W-1:0] m_axis_tuser;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // predictor state: calibration copy, running best sample, last accepted time
  cfg_t               cal;
  logic [COORD_W-1:0] run_x = '0;
  logic [COORD_W-1:0] run_y = '0;
  logic [COORD_W-1:0] run_z = '0;
  logic [TIME_W-1:0]  last_touch_ms = '0;
  logic [TIME_W-1:0]  clock_ms = '0;

  touch_res_t  touch_q[$];
  step_row_t   plan[$];
  int unsigned err_count = 0;
  int unsigned cycles = 0;
  int          hold_left = 0;
  bit          quiet = 1'b0;

  touch_sample_qualify_map_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_touch_sample_qualify_map_top: errors");
      $finish;
    end
  end

  task automatic report_err(input string msg);
    $display("%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_err($sformatf("%s: got %0d expected %0d", what, got, want));
  endtask

  // clamp to the calibration span, scale to the screen, optionally invert
  function automatic logic [COORD_W-1:0] scale_axis(input logic [COORD_W-1:0] raw,
      input logic [COORD_W-1:0] lo, input logic [COORD_W-1:0] hi,
      input int unsigned size, input bit inv);
    int unsigned v;
    int unsigned n;
    v = raw;
    if (raw < lo) v = lo;
    else if (raw > hi) v = hi;
    if (hi <= lo) return '0;
    n = ((v - lo) * (size - 1)) / (hi - lo);
    if (inv) n = size - 1 - n;
    return n[COORD_W-1:0];
  endfunction

  // track the best sample, qualify and map at the end of a burst
  function automatic bit qualify_touch(input sample_t s, output touch_res_t r);
    logic [COORD_W-1:0] bx, by, bz, mx, my;
    logic [TIME_W-1:0]  since;
    if (s.raw_z > run_z) begin
      run_x = s.raw_x;
      run_y = s.raw_y;
      run_z = s.raw_z;
    end
    if (!s.burst_last) return 1'b0;
    bx = run_x;
    by = run_y;
    bz = run_z;
    run_x = '0;
    run_y = '0;
    run_z = '0;
    since = s.now_ms - last_touch_ms;
    r.touched = 1'b0;
    r.scr_x = '0;
    r.scr_y = '0;
    r.best_x = bx;
    r.best_y = by;
    r.best_z = bz;
    if (cal.orient[OF_IRQ] && !s.pen_down) r.code = REJ_PEN_UP;
    else if (bz < cal.p_low || bz > cal.p_high) r.code = REJ_PRESSURE;
    else if (since < cal.debounce) r.code = REJ_DEBOUNCE;
    else r.code = REJ_NONE;
    if (r.code == REJ_NONE) begin
      last_touch_ms = s.now_ms;
      r.touched = 1'b1;
      mx = cal.orient[OF_SWAP] ? by : bx;
      my = cal.orient[OF_SWAP] ? bx : by;
      r.scr_x = scale_axis(mx, cal.x_low, cal.x_high, SCREEN_WIDTH, cal.orient[OF_INV_X]);
      r.scr_y = scale_axis(my, cal.y_low, cal.y_high, SCREEN_HEIGHT, cal.orient[OF_INV_Y]);
    end
    return 1'b1;
  endfunction

  // register write, then read back the stored value
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] want;
    case (idx)
      REG_ORIENT:   mask = 32'h0000_000f;
      REG_DEBOUNCE: mask = 32'h0000_ffff;
      default:      mask = 32'h0000_0fff;
    endcase
    want = val & mask;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= $urandom_range(0, 1) ? (want | ($urandom() & ~mask)) : want;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_X_LOW:    cal.x_low    = want[COORD_W-1:0];
      REG_X_HIGH:   cal.x_high   = want[COORD_W-1:0];
      REG_Y_LOW:    cal.y_low    = want[COORD_W-1:0];
      REG_Y_HIGH:   cal.y_high   = want[COORD_W-1:0];
      REG_P_LOW:    cal.p_low    = want[COORD_W-1:0];
      REG_P_HIGH:   cal.p_high   = want[COORD_W-1:0];
      REG_ORIENT:   cal.orient   = want[FLAG_W-1:0];
      REG_DEBOUNCE: cal.debounce = want[DEB_W-1:0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field($sformatf("readback of %s", idx.name()), prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(input cfg_t c);
    write_reg(REG_X_LOW, c.x_low);
    write_reg(REG_X_HIGH, c.x_high);
    write_reg(REG_Y_LOW, c.y_low);
    write_reg(REG_Y_HIGH, c.y_high);
    write_reg(REG_P_LOW, c.p_low);
    write_reg(REG_P_HIGH, c.p_high);
    write_reg(REG_ORIENT, c.orient);
    write_reg(REG_DEBOUNCE, c.debounce);
  endtask

  // drain the result stream and let the mapper finish before a register write
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (touch_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // send one sample, predict at its transaction
  task automatic push_sample(input sample_t s, input bit lit, input touch_res_t lit_res);
    touch_res_t r;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, s.now_ms, s.raw_z, s.raw_y, s.raw_x};
    s_axis_tuser  <= s.pen_down;
    s_axis_tlast  <= s.burst_last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (qualify_touch(s, r)) touch_q.push_back(lit ? lit_res : r);
  endtask

  function automatic cfg_t pick_cfg(input int unsigned phase);
    cfg_t c;
    logic [COORD_W-1:0] a, b;
    case (phase)
      0: c = '0;
      1: c = '1;
      2: begin
        c.x_low = RST_X_LOW;   c.x_high = RST_X_HIGH;
        c.y_low = RST_Y_LOW;   c.y_high = RST_Y_HIGH;
        c.p_low = RST_P_LOW;   c.p_high = RST_P_HIGH;
        c.orient = RST_ORIENT; c.debounce = RST_DEBOUNCE;
      end
      default: begin
        // spans mostly in order, sometimes inverted
        a = $urandom(); b = $urandom();
        c.x_low  = (a > b && $urandom_range(0, 6) != 0) ? b : a;
        c.x_high = (c.x_low == a) ? b : a;
        a = $urandom(); b = $urandom();
        c.y_low  = (a > b && $urandom_range(0, 6) != 0) ? b : a;
        c.y_high = (c.y_low == a) ? b : a;
        if ($urandom_range(0, 7) == 0) begin
          c.p_low  = $urandom_range(3000, 4095);
          c.p_high = $urandom_range(0, 2999);
        end else begin
          c.p_low  = $urandom_range(0, 1500);
          c.p_high = $urandom_range(1500, 4095);
        end
        c.orient = $urandom();
        case ($urandom_range(0, 3))
          0: c.debounce = '0;
          1: c.debounce = $urandom_range(1, 300);
          2: c.debounce = $urandom_range(300, 5000);
          default: c.debounce = $urandom();
        endcase
      end
    endcase
    return c;
  endfunction

  // mostly in-range coordinates and pressure, pen down; time moves on at burst end
  function automatic sample_t make_sample(input bit closing);
    sample_t s;
    int unsigned pick;
    s.raw_x = ($urandom_range(0, 3) != 0) ? $urandom_range(cal.x_low, cal.x_high) : $urandom();
    s.raw_y = ($urandom_range(0, 3) != 0) ? $urandom_range(cal.y_low, cal.y_high) : $urandom();
    pick = $urandom_range(0, 19);
    if (pick == 0) s.raw_z = '0;
    else if (pick < 15) s.raw_z = $urandom_range(cal.p_low, cal.p_high);
    else s.raw_z = $urandom();
    s.pen_down   = ($urandom_range(0, 9) != 0);
    s.burst_last = closing;
    if (closing) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: clock_ms += $urandom_range(0, 2 * cal.debounce + 2);
        6, 7, 8:          clock_ms += $urandom_range(0, 1000);
        default:          clock_ms += $urandom();
      endcase
      s.now_ms = clock_ms;
    end else begin
      s.now_ms = $urandom();
    end
    return s;
  endfunction

  function automatic step_row_t cfg_row(input reg_idx_e idx, input logic [31:0] v);
    step_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = v;
    r.lit = 1'b0;
    return r;
  endfunction

  function automatic step_row_t smp_row(input logic [COORD_W-1:0] x, y, z,
      input logic pen, last, input logic [TIME_W-1:0] now);
    step_row_t r;
    r.is_cfg = 1'b0;
    r.smp = '{x, y, z, pen, last, now};
    r.lit = 1'b0;
    return r;
  endfunction

  function automatic step_row_t lit_row(input step_row_t r, input logic t, input rej_e c,
      input logic [COORD_W-1:0] sx, sy, bx, by, bz);
    r.lit = 1'b1;
    r.res = '{t, c, sx, sy, bx, by, bz};
    return r;
  endfunction

  // result stream stalls in bursts
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest predicted touch
  always @(posedge clk_i) begin : check_out
    touch_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (touch_q.size() == 0) begin
        report_err($sformatf("unexpected result, tuser %0h tdata %0h",
                             m_axis_tuser, m_axis_tdata));
      end else begin
        want = touch_q.pop_front();
        check_field("touched", m_axis_tuser[0], want.touched);
        check_field("reject_code", m_axis_tuser[2:1], want.code);
        check_field("screen_x", m_axis_tdata[11:0], want.scr_x);
        check_field("screen_y", m_axis_tdata[23:12], want.scr_y);
        check_field("best_x", m_axis_tdata[35:24], want.best_x);
        check_field("best_y", m_axis_tdata[47:36], want.best_y);
        check_field("best_z", m_axis_tdata[59:48], want.best_z);
      end
    end
  end

  initial begin
    touch_res_t  none;
    int unsigned sent;
    int unsigned burst_len;
    none = '{1'b0, REJ_NONE, '0, '0, '0, '0, '0};
    cal.x_low = RST_X_LOW;   cal.x_high = RST_X_HIGH;
    cal.y_low = RST_Y_LOW;   cal.y_high = RST_Y_HIGH;
    cal.p_low = RST_P_LOW;   cal.p_high = RST_P_HIGH;
    cal.orient = RST_ORIENT; cal.debounce = RST_DEBOUNCE;

    // directed: reset settings first
    // all-zero burst falls below the pressure window
    plan.push_back(lit_row(smp_row(0, 0, 0, 0, 1, 0), 0, REJ_PRESSURE, 0, 0, 0, 0, 0));
    // full-scale sample too soon after time zero
    plan.push_back(lit_row(smp_row(4095, 4095, 4095, 1, 1, 100),
                           0, REJ_DEBOUNCE, 0, 0, 4095, 4095, 4095));
    // pressure tie keeps the first sample; low clamp, x inverted
    plan.push_back(smp_row(10, 20, 1000, 1, 0, 5));
    plan.push_back(smp_row(30, 40, 1000, 1, 0, 6));
    plan.push_back(lit_row(smp_row(50, 60, 999, 1, 1, 1000),
                           1, REJ_NONE, 319, 0, 10, 20, 1000));
    // exactly the debounce interval later, high clamp
    plan.push_back(lit_row(smp_row(4095, 4095, 4095, 1, 1, 1220),
                           1, REJ_NONE, 0, 239, 4095, 4095, 4095));
    // pressure one below and at the low bound
    plan.push_back(lit_row(smp_row(2000, 2000, 199, 1, 1, 5000),
                           0, REJ_PRESSURE, 0, 0, 2000, 2000, 199));
    plan.push_back(smp_row(2000, 2000, 200, 1, 1, 5000));
    // one millisecond short of the interval
    plan.push_back(lit_row(smp_row(1234, 2345, 3000, 1, 1, 5219),
                           0, REJ_DEBOUNCE, 0, 0, 1234, 2345, 3000));
    // time wraps past 2^32
    plan.push_back(smp_row(700, 800, 300, 1, 1, 32'hffff_ffff));
    plan.push_back(lit_row(smp_row(700, 800, 300, 1, 1, 218),
                           0, REJ_DEBOUNCE, 0, 0, 700, 800, 300));
    plan.push_back(smp_row(900, 900, 300, 1, 1, 219));
    // swap, invert both, interrupt line fitted: pen up on the last sample
    plan.push_back(cfg_row(REG_ORIENT, 4'hf));
    plan.push_back(smp_row(1000, 1000, 2000, 1, 0, 0));
    plan.push_back(lit_row(smp_row(5, 5, 100, 0, 1, 100000),
                           0, REJ_PEN_UP, 0, 0, 1000, 1000, 2000));
    plan.push_back(smp_row(1500, 2500, 2500, 0, 0, 0));
    plan.push_back(smp_row(0, 0, 0, 1, 1, 200000));
    // inverted pressure window rejects everything
    plan.push_back(cfg_row(REG_P_LOW, 3000));
    plan.push_back(cfg_row(REG_P_HIGH, 1000));
    plan.push_back(lit_row(smp_row(3, 4, 2000, 1, 1, 400000),
                           0, REJ_PRESSURE, 0, 0, 3, 4, 2000));
    // empty and inverted spans map to zero, no debounce
    plan.push_back(cfg_row(REG_P_LOW, 0));
    plan.push_back(cfg_row(REG_P_HIGH, 4095));
    plan.push_back(cfg_row(REG_X_LOW, 2000));
    plan.push_back(cfg_row(REG_X_HIGH, 2000));
    plan.push_back(cfg_row(REG_Y_LOW, 3000));
    plan.push_back(cfg_row(REG_Y_HIGH, 100));
    plan.push_back(cfg_row(REG_DEBOUNCE, 0));
    plan.push_back(lit_row(smp_row(4095, 0, 1, 1, 1, 400001),
                           1, REJ_NONE, 0, 0, 4095, 0, 1));
    plan.push_back(lit_row(smp_row(4095, 4095, 0, 1, 1, 400001),
                           1, REJ_NONE, 0, 0, 0, 0, 0));

    // reset
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        push_sample(plan[i].smp, plan[i].lit, plan[i].res);
      end
    end

    // random bursts under several settings, no idling in the last phase
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase == PHASES - 1) quiet = 1'b1;
      apply_cfg(pick_cfg(phase));
      clock_ms = last_touch_ms + $urandom_range(0, 70000);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                : $urandom_range(1, 6);
        for (int unsigned k = 0; k < burst_len; k++)
          push_sample(make_sample(k == burst_len - 1), 1'b0, none);
        sent += burst_len;
      end
    end

    settle();
    if (err_count == 0) begin
      $display("tb_touch_sample_qualify_map_top: clean");
    end else begin
      $display("tb_touch_sample_qualify_map_top: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tsqm_pkg.sv
rtl/tsqm_regs.sv
rtl/tsqm_ctrl.sv
rtl/tsqm_dp.sv
rtl/touch_sample_qualify_map_top.sv
rtl/tsqm_checker.sv
tb/tb_touch_sample_qualify_map_top.sv
